// ===== design/sfr_pkg.sv =====
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int JOB_BYTES   = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = $clog2(JOB_BYTES);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 3'd3;

  typedef logic [JOB_BYTES-1:0][7:0] byte_vec_t;

  // One queue entry: up to JOB_BYTES output bytes, byte 0 first.
  // A count of zero with last set stands for the empty end marker.
  typedef struct packed {
    byte_vec_t              bytes;
    logic [LEN_W-1:0]       count;
    logic                   last;
  } job_t;

endpackage

// ===== design/sfr_front.sv =====
module sfr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  output logic                            push,
  output sfr_pkg::job_t                   job
);
  import sfr_pkg::*;

  logic [63:0]                   pattern_bytes;
  logic [LEN_W-1:0]              pattern_len;
  logic [63:0]                   replacement_bytes;
  logic [LEN_W-1:0]              replacement_len;
  logic [MAX_PATTERN-1:0][7:0]   window;
  logic [LEN_W-1:0]              fill;

  logic [MAX_PATTERN-1:0][7:0]   win_new;
  logic [MAX_PATTERN-1:0][7:0]   window_next;
  logic [LEN_W-1:0]              fill_next;
  logic [LEN_W-1:0]              plen;
  logic [LEN_W-1:0]              rlen;
  logic [LEN_W-1:0]              fill_eff;
  logic [LEN_W-1:0]              fill_new;
  logic                          full;
  logic                          hit;

  assign plen = (pattern_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern_len;
  assign rlen = (replacement_len > LEN_W'(MAX_REPLACE)) ? LEN_W'(MAX_REPLACE)
                                                         : replacement_len;
  assign fill_eff = (fill >= plen) ? '0 : fill;
  assign fill_new = fill_eff + LEN_W'(1);
  assign full     = (fill_new == plen);

  always_comb begin
    win_new = window;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) == fill_eff) win_new[i] = in_byte;
    end
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < plen && win_new[i] != pattern_bytes[i*8 +: 8]) hit = 1'b0;
    end
  end

  // Classify the item into one queue entry
  always_comb begin
    job.bytes = win_new;
    job.count = '0;
    job.last  = in_last;
    if (plen == '0) begin
      job.bytes    = '0;
      job.bytes[0] = in_byte;
      job.count    = LEN_W'(1);
    end else if (full && hit) begin
      job.bytes = replacement_bytes;
      job.count = rlen;
    end else if (full) begin
      job.count = in_last ? plen : LEN_W'(1);
    end else begin
      job.count = in_last ? fill_new : '0;
    end
  end

  assign push = accept && (job.count != '0 || in_last);

  always_comb begin
    window_next = win_new;
    fill_next   = fill_new;
    if (full && !hit) begin
      // slide on by one
      for (int i = 0; i < MAX_PATTERN - 1; i++) window_next[i] = win_new[i+1];
      fill_next = plen - LEN_W'(1);
    end else if (full) begin
      fill_next = '0;
    end
    if (in_last) fill_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_len       <= '0;
      replacement_bytes <= '0;
      replacement_len   <= '0;
      window            <= '0;
      fill              <= '0;
    end else begin
      if (accept && plen != '0) begin
        window <= window_next;
        fill   <= fill_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_BYTES: pattern_bytes <= cfg_data;
          REG_PATTERN_LEN: begin
            pattern_len <= cfg_data[LEN_W-1:0];
            fill        <= '0;
          end
          REG_REPLACEMENT_BYTES: replacement_bytes <= cfg_data;
          REG_REPLACEMENT_LEN:   replacement_len   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (plen != '0) |-> (fill < plen))
    else $error("window fill reached pattern length");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_last && !cfg_we) |=> (fill == '0))
    else $error("window not flushed after last item");

endmodule

// ===== design/sfr_queue.sv =====
module sfr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sfr_pkg::job_t   push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output sfr_pkg::job_t   head
);
  import sfr_pkg::*;

  job_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

endmodule

// ===== design/sfr_back.sv =====
module sfr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  sfr_pkg::job_t   head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tuser,
  output logic            m_tlast
);
  import sfr_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic              load;
  logic              job_done;

  assign job_done = (head.count == '0) || ({1'b0, idx} == head.count - LEN_W'(1));
  assign load     = head_valid && (!m_tvalid || m_tready);
  assign pop      = load && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= job_done ? '0 : idx + IDX_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= (head.count == '0) ? 8'h00 : head.bytes[idx];
      m_tuser <= (head.count != '0);
      m_tlast <= head.last && job_done;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.count != '0) |-> ({1'b0, idx} < head.count))
    else $error("byte index past end of entry");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("empty marker not at end of stream");

endmodule

// ===== design/stream_find_replace.sv =====
// Byte stream find and replace.
// Input stream: s_tdata carries one text byte, s_tlast marks the final byte of a
// stream and flushes any bytes still held for matching.
// Output stream: m_tdata carries a byte, m_tuser is set when that byte is real
// data and clear on the empty end marker, m_tlast marks the final item of the
// stream. Every leftmost, non-overlapping occurrence of the pattern is replaced.
// Config: write pattern bytes, pattern length, replacement bytes and replacement
// length through cfg_we/cfg_index/cfg_data while the stream is idle; writing the
// pattern length drops held bytes. Pattern length zero passes bytes through.
// A byte that produces output is classified and written into the queue at the
// edge that takes it, then moves into the output register once that is free.
// Throughput: one input item per cycle while each item yields at most one output
// byte and m_tready stays high; a replacement or flush leaves byte by byte from
// one queue entry. While such a burst drains the two-entry queue holds one more
// producing item, then s_tready drops until the burst ends. When the receiver
// stalls the output register holds, the queue fills and s_tready goes low. Reset
// clears the config, held bytes, queue and m_tvalid; no clearing pass.
module stream_find_replace (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] in_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic                            m_tuser,   // [0] out_valid
  output logic                            m_tlast
);
  import sfr_pkg::*;

  logic  accept;
  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;
  job_t  push_job;
  job_t  head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .job       (push_job)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
